[design/pie_pkg.sv]
package pie_pkg;

    // default sizes
    localparam int OP_DEPTH_DEF   = 16;
    localparam int NUM_DEPTH_DEF  = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int OP_BITS  = 3;
    localparam int OUT_BITS = 32;

    // character codes
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] DIGIT_BASE = 8'd48;

    // operator stack codes
    typedef enum logic [OP_BITS-1:0] {
        OP_LPAREN = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4
    } op_code_t;

    // error codes
    typedef logic [1:0] err_code_t;
    localparam err_code_t ERR_OK        = 2'd0;
    localparam err_code_t ERR_DIV_ZERO  = 2'd1;
    localparam err_code_t ERR_UNDERFLOW = 2'd2;
    localparam err_code_t ERR_OVERFLOW  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture the incoming beat
        logic op_push;     // push operator or open bracket
        logic num_new;     // push a fresh digit
        logic digit_wb;    // extend top number by a digit
        logic clr_run;     // end of a digit run
        logic rd_top;      // read top number
        logic rd_pair;     // read second number and top operator
        logic err_under;   // record underflow
        logic close_exec;  // pop pair and combine
        logic iter_wb;     // write back multiply / divide result
        logic emit;        // load result register and reset stacks
    } pie_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_op;
        logic is_close;
        logic can_extend;
        logic close_ok;
        logic last;
        logic iter_go;
        logic iter_done;
    } pie_stat_t;

endpackage

[design/pie_ram.sv]
module pie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/pie_muldiv.sv]
module pie_muldiv #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic         is_div,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         done,
    output logic [W-1:0] result
);

    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          div_reg, div_next;
    logic          neg_reg, neg_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (~v + W'(1)) : v;
    endfunction

    assign trial = {rem_reg, x_reg[W-1]};
    assign diff  = trial - {1'b0, y_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            div_next  = is_div;
            neg_next  = a[W-1] ^ b[W-1];
            x_next    = is_div ? mag(a) : a;
            y_next    = is_div ? mag(b) : b;
            acc_next  = '0;
            rem_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + CW'(1);
            x_next   = {x_reg[W-2:0], 1'b0};
            if (div_reg) begin
                // restoring step, one quotient bit
                if (!diff[W]) begin
                    rem_next = diff[W-1:0];
                    acc_next = {acc_reg[W-2:0], 1'b1};
                end else begin
                    rem_next = trial[W-1:0];
                    acc_next = {acc_reg[W-2:0], 1'b0};
                end
            end else begin
                // shift and add, low half only
                y_next = {1'b0, y_reg[W-1:1]};
                if (y_reg[0]) begin
                    acc_next = acc_reg + x_reg;
                end
            end
            if (cnt_reg == CW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign done   = done_reg;
    assign result = (div_reg && neg_reg) ? (~acc_reg + W'(1)) : acc_reg;

endmodule

[design/pie_datapath.sv]
module pie_datapath #(
    parameter int OP_DEPTH   = pie_pkg::OP_DEPTH_DEF,
    parameter int NUM_DEPTH  = pie_pkg::NUM_DEPTH_DEF,
    parameter int VALUE_BITS = pie_pkg::VALUE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pie_pkg::pie_cmd_t           cmd,
    output pie_pkg::pie_stat_t          stat,
    input  logic [7:0]                  char_in,
    input  logic                        last_in,
    output logic [pie_pkg::OUT_BITS-1:0] out_value,
    output pie_pkg::err_code_t          out_error
);

    localparam int OAW = $clog2(OP_DEPTH);
    localparam int OCW = $clog2(OP_DEPTH + 1);
    localparam int NAW = $clog2(NUM_DEPTH);
    localparam int NCW = $clog2(NUM_DEPTH + 1);
    localparam int VB  = VALUE_BITS;

    logic [7:0]               char_reg;
    logic                     last_reg;
    logic [VB-1:0]            rhs_reg;
    logic [OCW-1:0]           op_cnt_reg, op_cnt_next;
    logic [NCW-1:0]           num_cnt_reg, num_cnt_next;
    logic                     run_reg, run_next;
    pie_pkg::err_code_t       err_reg, err_next;
    logic [pie_pkg::OUT_BITS-1:0] out_value_reg;
    pie_pkg::err_code_t       out_error_reg;

    logic                     op_we;
    logic [OAW-1:0]           op_waddr;
    logic [pie_pkg::OP_BITS-1:0] op_wdata;
    logic [OAW-1:0]           op_raddr;
    logic [pie_pkg::OP_BITS-1:0] op_rdata;

    logic                     num_we;
    logic [NAW-1:0]           num_waddr;
    logic [VB-1:0]            num_wdata;
    logic                     num_re;
    logic [NAW-1:0]           num_raddr;
    logic [VB-1:0]            num_rdata;

    logic [VB-1:0]            digit_val;
    logic [VB-1:0]            ext_val;
    logic [NCW-1:0]           cnt_m1;
    logic [NCW-1:0]           cnt_m2;
    logic                     is_op;
    logic                     rhs_zero;
    logic                     iter_go;
    logic                     iter_done;
    logic [VB-1:0]            iter_result;
    logic signed [VB-1:0]     top_signed;
    pie_pkg::op_code_t        push_code;

    always_comb begin
        is_op     = 1'b1;
        push_code = pie_pkg::OP_LPAREN;
        case (char_reg)
            pie_pkg::CH_LPAREN: push_code = pie_pkg::OP_LPAREN;
            pie_pkg::CH_PLUS:   push_code = pie_pkg::OP_ADD;
            pie_pkg::CH_MINUS:  push_code = pie_pkg::OP_SUB;
            pie_pkg::CH_STAR:   push_code = pie_pkg::OP_MUL;
            pie_pkg::CH_SLASH:  push_code = pie_pkg::OP_DIV;
            default:            is_op     = 1'b0;
        endcase
    end

    assign digit_val = VB'(char_reg) - VB'(pie_pkg::DIGIT_BASE);
    assign ext_val   = (num_rdata << 3) + (num_rdata << 1) + digit_val;
    assign cnt_m1    = num_cnt_reg - NCW'(1);
    assign cnt_m2    = num_cnt_reg - NCW'(2);
    assign rhs_zero  = (rhs_reg == '0);
    assign iter_go   = (op_rdata == pie_pkg::OP_MUL) ||
                       ((op_rdata == pie_pkg::OP_DIV) && !rhs_zero);
    assign top_signed = num_rdata;

    assign num_re    = cmd.rd_top | cmd.rd_pair;
    assign num_raddr = cmd.rd_pair ? cnt_m2[NAW-1:0] : cnt_m1[NAW-1:0];
    assign op_raddr  = OAW'(op_cnt_reg - OCW'(1));

    always_comb begin
        op_cnt_next  = op_cnt_reg;
        num_cnt_next = num_cnt_reg;
        run_next     = run_reg;
        err_next     = err_reg;
        op_we        = 1'b0;
        op_waddr     = op_cnt_reg[OAW-1:0];
        op_wdata     = push_code;
        num_we       = 1'b0;
        num_waddr    = num_cnt_reg[NAW-1:0];
        num_wdata    = digit_val;

        if (cmd.clr_run) begin
            run_next = 1'b0;
        end

        if (cmd.op_push) begin
            if (op_cnt_reg < OCW'(OP_DEPTH)) begin
                op_we       = 1'b1;
                op_cnt_next = op_cnt_reg + OCW'(1);
            end else if (err_reg == pie_pkg::ERR_OK) begin
                err_next = pie_pkg::ERR_OVERFLOW;
            end
        end

        if (cmd.num_new) begin
            run_next = 1'b1;
            if (num_cnt_reg < NCW'(NUM_DEPTH)) begin
                num_we       = 1'b1;
                num_cnt_next = num_cnt_reg + NCW'(1);
            end else if (err_reg == pie_pkg::ERR_OK) begin
                err_next = pie_pkg::ERR_OVERFLOW;
            end
        end

        if (cmd.digit_wb) begin
            run_next  = 1'b1;
            num_we    = 1'b1;
            num_waddr = cnt_m1[NAW-1:0];
            num_wdata = ext_val;
        end

        if (cmd.err_under && (err_reg == pie_pkg::ERR_OK)) begin
            err_next = pie_pkg::ERR_UNDERFLOW;
        end

        if (cmd.close_exec) begin
            // pair popped; result, if any, lands on the lower slot
            op_cnt_next = op_cnt_reg - OCW'(2);
            num_waddr   = cnt_m2[NAW-1:0];
            case (op_rdata)
                pie_pkg::OP_ADD: begin
                    num_we       = 1'b1;
                    num_wdata    = num_rdata + rhs_reg;
                    num_cnt_next = cnt_m1;
                end
                pie_pkg::OP_SUB: begin
                    num_we       = 1'b1;
                    num_wdata    = num_rdata - rhs_reg;
                    num_cnt_next = cnt_m1;
                end
                pie_pkg::OP_MUL: begin
                    num_cnt_next = num_cnt_reg;
                end
                pie_pkg::OP_DIV: begin
                    if (rhs_zero) begin
                        num_we       = 1'b1;
                        num_wdata    = '0;
                        num_cnt_next = cnt_m1;
                        if (err_reg == pie_pkg::ERR_OK) begin
                            err_next = pie_pkg::ERR_DIV_ZERO;
                        end
                    end
                end
                default: begin
                    num_cnt_next = cnt_m2;
                end
            endcase
        end

        if (cmd.iter_wb) begin
            num_we       = 1'b1;
            num_waddr    = cnt_m2[NAW-1:0];
            num_wdata    = iter_result;
            num_cnt_next = cnt_m1;
        end

        if (cmd.emit) begin
            op_cnt_next  = '0;
            num_cnt_next = '0;
            run_next     = 1'b0;
            err_next     = pie_pkg::ERR_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_cnt_reg  <= '0;
            num_cnt_reg <= '0;
            run_reg     <= 1'b0;
            err_reg     <= pie_pkg::ERR_OK;
        end else begin
            op_cnt_reg  <= op_cnt_next;
            num_cnt_reg <= num_cnt_next;
            run_reg     <= run_next;
            err_reg     <= err_next;
        end
        if (cmd.load) begin
            char_reg <= char_in;
            last_reg <= last_in;
        end
        if (cmd.rd_pair) begin
            rhs_reg <= num_rdata;
        end
        if (cmd.emit) begin
            if (num_cnt_reg == '0) begin
                out_value_reg <= '0;
                out_error_reg <= (err_reg == pie_pkg::ERR_OK) ? pie_pkg::ERR_UNDERFLOW
                                                              : err_reg;
            end else begin
                out_value_reg <= pie_pkg::OUT_BITS'(top_signed);
                out_error_reg <= err_reg;
            end
        end
    end

    pie_ram #(
        .WIDTH (pie_pkg::OP_BITS),
        .DEPTH (OP_DEPTH)
    ) u_op_ram (
        .aclk  (aclk),
        .we    (op_we),
        .waddr (op_waddr),
        .wdata (op_wdata),
        .re    (cmd.rd_pair),
        .raddr (op_raddr),
        .rdata (op_rdata)
    );

    pie_ram #(
        .WIDTH (VB),
        .DEPTH (NUM_DEPTH)
    ) u_num_ram (
        .aclk  (aclk),
        .we    (num_we),
        .waddr (num_waddr),
        .wdata (num_wdata),
        .re    (num_re),
        .raddr (num_raddr),
        .rdata (num_rdata)
    );

    pie_muldiv #(
        .W (VB)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.close_exec & iter_go),
        .is_div  (op_rdata == pie_pkg::OP_DIV),
        .a       (num_rdata),
        .b       (rhs_reg),
        .done    (iter_done),
        .result  (iter_result)
    );

    assign stat.is_op      = is_op;
    assign stat.is_close   = (char_reg == pie_pkg::CH_RPAREN);
    assign stat.can_extend = run_reg && (num_cnt_reg != '0);
    assign stat.close_ok   = (num_cnt_reg >= NCW'(2)) && (op_cnt_reg >= OCW'(2));
    assign stat.last       = last_reg;
    assign stat.iter_go    = iter_go;
    assign stat.iter_done  = iter_done;

    assign out_value = out_value_reg;
    assign out_error = out_error_reg;

endmodule

[design/pie_ctrl.sv]
module pie_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  pie_pkg::pie_stat_t stat,
    output pie_pkg::pie_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIGIT,
        S_RD_LHS,
        S_OPER,
        S_ITER,
        S_END,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (stat.is_op) begin
                    cmd.op_push = 1'b1;
                    cmd.clr_run = 1'b1;
                    state_next  = S_END;
                end else if (stat.is_close) begin
                    cmd.clr_run = 1'b1;
                    if (stat.close_ok) begin
                        cmd.rd_top = 1'b1;
                        state_next = S_RD_LHS;
                    end else begin
                        cmd.err_under = 1'b1;
                        state_next    = S_END;
                    end
                end else if (stat.can_extend) begin
                    cmd.rd_top = 1'b1;
                    state_next = S_DIGIT;
                end else begin
                    cmd.num_new = 1'b1;
                    state_next  = S_END;
                end
            end
            S_DIGIT: begin
                cmd.digit_wb = 1'b1;
                state_next   = S_END;
            end
            S_RD_LHS: begin
                cmd.rd_pair = 1'b1;
                state_next  = S_OPER;
            end
            S_OPER: begin
                cmd.close_exec = 1'b1;
                state_next     = stat.iter_go ? S_ITER : S_END;
            end
            S_ITER: begin
                if (stat.iter_done) begin
                    cmd.iter_wb = 1'b1;
                    state_next  = S_END;
                end
            end
            S_END: begin
                if (stat.last) begin
                    cmd.rd_top = 1'b1;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.emit      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

[design/paren_infix_evaluator_unit.sv]
// channel   dir  beat carries                         handshake
// s_        in   tdata[7:0] char_code, tlast last     s_tvalid / s_tready
// m_        out  tdata[31:0] value, [33:32] error     m_tvalid / m_tready
//
// sequencing: each beat is loaded, dispatched and ended; a digit that extends a number
//   adds a read-modify-write, a closing bracket reads both operands before combining them,
//   and one with * or a non-zero / waits on the shift-add multiplier / restoring divider,
//   one bit a cycle; the final beat then loads the result, held while an earlier one waits
// reset: synchronous, active low; both stacks need no clearing pass
// stalls: a waiting result does not block input beats, only the next final one
module paren_infix_evaluator_unit #(
    parameter int OP_DEPTH   = pie_pkg::OP_DEPTH_DEF,
    parameter int NUM_DEPTH  = pie_pkg::NUM_DEPTH_DEF,
    parameter int VALUE_BITS = pie_pkg::VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input characters
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last character of the expression
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] value, [33:32] error, zero above
);

    pie_pkg::pie_cmd_t            cmd;
    pie_pkg::pie_stat_t           stat;
    logic [pie_pkg::OUT_BITS-1:0] out_value;
    pie_pkg::err_code_t           out_error;

    // sequencer: one character at a time, holds the result valid flag
    pie_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // both stacks, their counts, the sticky error and the arithmetic
    pie_datapath #(
        .OP_DEPTH   (OP_DEPTH),
        .NUM_DEPTH  (NUM_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .char_in   (s_tdata),
        .last_in   (s_tlast),
        .out_value (out_value),
        .out_error (out_error)
    );

    // result beat packing, value in the low word
    assign m_tdata = {6'b0, out_error, out_value};

endmodule
